/* design/scnd_pkg.sv */
// ----------------------------------------------------------------------------
// scnd_pkg
// Shared types for the serial command nibble decoder.
// ----------------------------------------------------------------------------
package scnd_pkg;

	typedef struct packed {
		logic        transmit_enable;
		logic [9:0]  tick_period_ms;
		logic        clear_elapsed;
		logic        led_pin_write;
		logic        led_level_write;
		logic [1:0]  led_slot;
		logic [3:0]  led_pin;
		logic [11:0] led_level;
		logic        single_led_always_on;
		logic        mode_updated;
		logic [26:0] duration_ms;
		logic        duration_done;
	} result_t;

endpackage

/* design/scnd_decode.sv */
// ----------------------------------------------------------------------------
// scnd_decode
// Command state and combinational decode of one received nibble.
// ----------------------------------------------------------------------------
module scnd_decode #(
	parameter int LED_SLOTS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [3:0]       nib,
	output scnd_pkg::result_t res
);
	import scnd_pkg::*;

	localparam int SLOT_W = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PIN   = 3'd1;
	localparam logic [2:0] PH_LEVEL = 3'd2;
	localparam logic [2:0] PH_MODE  = 3'd3;
	localparam logic [2:0] PH_DUR   = 3'd4;

	localparam logic [3:0] CMD_TX_OFF   = 4'd0;
	localparam logic [3:0] CMD_TX_ON    = 4'd1;
	localparam logic [3:0] CMD_TICK_1   = 4'd2;
	localparam logic [3:0] CMD_TICK_10  = 4'd3;
	localparam logic [3:0] CMD_TICK_100 = 4'd4;
	localparam logic [3:0] CMD_TICK_1K  = 4'd5;
	localparam logic [3:0] CMD_CLEAR    = 4'd6;
	localparam logic [3:0] CMD_LED_SET  = 4'd7;
	localparam logic [3:0] CMD_DURATION = 4'd8;

	localparam logic [2:0] LAST_DIGIT = 3'd4;
	localparam int         DSUM_W     = 18;         // 15 * 11111 fits
	localparam int         FIN_W      = 29;
	localparam int         DUR_SCALE  = 1000;
	localparam int         TOP_SCALE  = 10000 * DUR_SCALE;
	localparam int         DUR_MAX    = 99999000;

	function automatic logic [11:0] level_code(input logic [3:0] n);
		logic [11:0] v;
		unique case (n)
			4'd0:    v = 12'd0;
			4'd1:    v = 12'd1737;
			4'd2:    v = 12'd1861;
			4'd3:    v = 12'd1985;
			4'd4:    v = 12'd2109;
			4'd5:    v = 12'd2233;
			4'd6:    v = 12'd2357;
			4'd7:    v = 12'd2481;
			default: v = 12'd2048;
		endcase
		return v;
	endfunction

	function automatic logic [9:0] tick_ms(input logic [1:0] sel);
		logic [9:0] v;
		unique case (sel)
			2'd0:    v = 10'd1;
			2'd1:    v = 10'd10;
			2'd2:    v = 10'd100;
			default: v = 10'd1000;
		endcase
		return v;
	endfunction

	// weights of the first four digits; the fifth is folded into the scaling
	function automatic logic [9:0] digit_weight(input logic [2:0] pos);
		logic [9:0] v;
		unique case (pos)
			3'd0:    v = 10'd1;
			3'd1:    v = 10'd10;
			3'd2:    v = 10'd100;
			default: v = 10'd1000;
		endcase
		return v;
	endfunction

	logic [2:0]        phase_q, phase_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [3:0]        pin_q, pin_d;
	logic [2:0]        dpos_q, dpos_d;
	logic [26:0]       acc_q, acc_d;
	logic              tx_q, tx_d;
	logic [1:0]        tick_q, tick_d;
	logic              mode_q, mode_d;

	logic [2:0]        pos;
	logic [FIN_W-1:0]  fin;

	always_comb begin
		phase_d = phase_q;
		slot_d  = slot_q;
		pin_d   = pin_q;
		dpos_d  = dpos_q;
		acc_d   = acc_q;
		tx_d    = tx_q;
		tick_d  = tick_q;
		mode_d  = mode_q;

		res = '0;

		pos = (dpos_q < 3'd5) ? dpos_q : LAST_DIGIT;
		// (acc + nib*10000) * 1000, split into two constant products
		fin = FIN_W'(acc_q[DSUM_W-1:0]) * FIN_W'(DUR_SCALE)
			+ FIN_W'(nib) * FIN_W'(TOP_SCALE);

		unique case (phase_q)
			PH_PIN: begin
				pin_d             = nib;
				res.led_pin_write = 1'b1;
				res.led_slot      = 2'(slot_q);
				res.led_pin       = nib;
				phase_d           = PH_LEVEL;
			end
			PH_LEVEL: begin
				res.led_level_write = 1'b1;
				res.led_slot        = 2'(slot_q);
				res.led_pin         = pin_q;
				res.led_level       = level_code(nib);
				if (slot_q == SLOT_W'(LED_SLOTS - 1)) begin
					slot_d  = '0;
					phase_d = PH_MODE;
				end else begin
					slot_d  = slot_q + 1'b1;
					phase_d = PH_PIN;
				end
			end
			PH_MODE: begin
				mode_d           = nib[0];
				res.mode_updated = 1'b1;
				phase_d          = PH_IDLE;
			end
			PH_DUR: begin
				if (pos == LAST_DIGIT) begin
					acc_d             = (fin > FIN_W'(DUR_MAX)) ? 27'(DUR_MAX) : 27'(fin);
					dpos_d            = '0;
					res.duration_done = 1'b1;
					phase_d           = PH_IDLE;
				end else begin
					acc_d  = acc_q + 27'(14'(nib) * 14'(digit_weight(pos)));
					dpos_d = pos + 3'd1;
				end
			end
			default: begin
				// idle, and any unused phase code
				phase_d = PH_IDLE;
				unique case (nib)
					CMD_TX_OFF:   tx_d   = 1'b0;
					CMD_TX_ON:    tx_d   = 1'b1;
					CMD_TICK_1:   tick_d = 2'd0;
					CMD_TICK_10:  tick_d = 2'd1;
					CMD_TICK_100: tick_d = 2'd2;
					CMD_TICK_1K:  tick_d = 2'd3;
					CMD_CLEAR:    res.clear_elapsed = 1'b1;
					CMD_LED_SET: begin
						slot_d  = '0;
						phase_d = PH_PIN;
					end
					CMD_DURATION: begin
						acc_d   = '0;
						dpos_d  = '0;
						phase_d = PH_DUR;
					end
					default: ;
				endcase
			end
		endcase

		res.transmit_enable      = tx_d;
		res.tick_period_ms       = tick_ms(tick_d);
		res.single_led_always_on = mode_d;
		res.duration_ms          = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			slot_q  <= '0;
			pin_q   <= '0;
			dpos_q  <= '0;
			acc_q   <= '0;
			tx_q    <= 1'b0;
			tick_q  <= 2'd0;
			mode_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			slot_q  <= slot_d;
			pin_q   <= pin_d;
			dpos_q  <= dpos_d;
			acc_q   <= acc_d;
			tx_q    <= tx_d;
			tick_q  <= tick_d;
			mode_q  <= mode_d;
		end
	end

endmodule

/* design/serial_command_nibble_decoder_core.sv */
// ----------------------------------------------------------------------------
// serial_command_nibble_decoder_core
// Decodes the low nibble of received bytes into transmit, tick, clear, LED setup, mode and duration updates.
// ----------------------------------------------------------------------------
// A request accepted into the input register (s1) is decoded and its result
// is taken into the result register (s2), which drives out_valid. Throughput:
// one request per cycle while out_stall does not hold a full result register;
// the decode is a single pass through the command state and result register.
// Reset: arst_n clears both valid flags and the command state (idle phase,
// transmit off, 1 ms tick, mode bit and duration cleared).
module serial_command_nibble_decoder_core #(
	parameter int LED_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        transmit_enable,
	output logic [9:0]  tick_period_ms,
	output logic        clear_elapsed,
	output logic        led_pin_write,
	output logic        led_level_write,
	output logic [1:0]  led_slot,
	output logic [3:0]  led_pin,
	output logic [11:0] led_level,
	output logic        single_led_always_on,
	output logic        mode_updated,
	output logic [26:0] duration_ms,
	output logic        duration_done
);
	import scnd_pkg::*;

	logic       valid_s1;
	logic [3:0] nib_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    dec_res;
	logic       in_take;
	logic       adv;

	// s1 moves on when the result register is empty or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	scnd_decode #(
		.LED_SLOTS(LED_SLOTS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.nib    (nib_s1),
		.res    (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			nib_s1 <= rx_byte[3:0];
		end
		if (adv) begin
			res_s2 <= dec_res;
		end
	end

	assign out_valid            = valid_s2;
	assign transmit_enable      = res_s2.transmit_enable;
	assign tick_period_ms       = res_s2.tick_period_ms;
	assign clear_elapsed        = res_s2.clear_elapsed;
	assign led_pin_write        = res_s2.led_pin_write;
	assign led_level_write      = res_s2.led_level_write;
	assign led_slot             = res_s2.led_slot;
	assign led_pin              = res_s2.led_pin;
	assign led_level            = res_s2.led_level;
	assign single_led_always_on = res_s2.single_led_always_on;
	assign mode_updated         = res_s2.mode_updated;
	assign duration_ms          = res_s2.duration_ms;
	assign duration_done        = res_s2.duration_done;

endmodule
